// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to leave them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, ignored while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset as well
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, ante, cons)

`endif

`endif

// ===== design/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants and types for the perspective point projection unit.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 32;
    localparam int REG_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int PIX_W   = 16;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROW_X_A   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_X_B   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Y_A   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW_Y_B   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW_D_A   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW_D_B   = 3'd5;
    localparam logic [IDX_W-1:0] REG_IMG_SIZE  = 3'd6;

    localparam logic [REG_W-1:0]  RST_ROW_X_A  = 64'd65536;
    localparam logic [REG_W-1:0]  RST_ROW_X_B  = 64'd0;
    localparam logic [REG_W-1:0]  RST_ROW_Y_A  = 64'd281474976710656;
    localparam logic [REG_W-1:0]  RST_ROW_Y_B  = 64'd0;
    localparam logic [REG_W-1:0]  RST_ROW_D_A  = 64'd0;
    localparam logic [REG_W-1:0]  RST_ROW_D_B  = 64'd65536;
    localparam logic [SIZE_W-1:0] RST_IMG_SIZE = 32'd31457920;

    // per-word flags carried alongside the divider data
    typedef struct packed {
        logic dz;     // depth is zero
        logic neg_c;  // column quotient is subtracted
        logic neg_r;  // row quotient is subtracted
        logic ovf_c;  // column quotient beyond the divider range
        logic ovf_r;  // row quotient beyond the divider range
    } t_flags;

endpackage

// ===== design/ppp_front.sv =====
// ----------------------------------------------------------------------------
// ppp_front
// Accepts points, applies the 3x4 matrix and flags zero depth.
// ----------------------------------------------------------------------------
module ppp_front #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF,
    parameter int SUM_W     = 66 - FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ppp_pkg::COORD_W-1:0]   i_x,
    input  logic [ppp_pkg::COORD_W-1:0]   i_y,
    input  logic [ppp_pkg::COORD_W-1:0]   i_z,
    input  logic [ppp_pkg::REG_W-1:0]     i_row_x_a,
    input  logic [ppp_pkg::REG_W-1:0]     i_row_x_b,
    input  logic [ppp_pkg::REG_W-1:0]     i_row_y_a,
    input  logic [ppp_pkg::REG_W-1:0]     i_row_y_b,
    input  logic [ppp_pkg::REG_W-1:0]     i_row_d_a,
    input  logic [ppp_pkg::REG_W-1:0]     i_row_d_b,
    output logic                          o_push,
    input  logic                          i_full,
    output logic [3*SUM_W:0]              o_entry
);

    localparam int PROD_W = 2 * ppp_pkg::COEF_W;

    logic                      en;
    logic                      r_v1, r_v2;
    logic signed [PROD_W-1:0]  r_p [9];
    logic signed [PROD_W-1:0]  n_p [9];
    logic signed [SUM_W-1:0]   r_tx, r_ty, r_td;
    logic signed [SUM_W-1:0]   n_sx, n_sy, n_sd;
    logic signed [SUM_W-1:0]   r_sx, r_sy, r_sd;

    assign en      = !r_v2 || !i_full;
    assign o_ready = en;
    assign o_push  = r_v2 && !i_full;

    function automatic logic signed [PROD_W-1:0] mul(input logic [31:0] c,
                                                     input logic [31:0] v);
        return $signed(c) * $signed(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] fsh(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRAC_BITS;
        return s[SUM_W-1:0];
    endfunction

    always_comb begin
        n_p[0] = mul(i_row_x_a[31:0],  i_x);
        n_p[1] = mul(i_row_x_a[63:32], i_y);
        n_p[2] = mul(i_row_x_b[31:0],  i_z);
        n_p[3] = mul(i_row_y_a[31:0],  i_x);
        n_p[4] = mul(i_row_y_a[63:32], i_y);
        n_p[5] = mul(i_row_y_b[31:0],  i_z);
        n_p[6] = mul(i_row_d_a[31:0],  i_x);
        n_p[7] = mul(i_row_d_a[63:32], i_y);
        n_p[8] = mul(i_row_d_b[31:0],  i_z);
        n_sx = fsh(r_p[0]) + fsh(r_p[1]) + fsh(r_p[2]) + r_tx;
        n_sy = fsh(r_p[3]) + fsh(r_p[4]) + fsh(r_p[5]) + r_ty;
        n_sd = fsh(r_p[6]) + fsh(r_p[7]) + fsh(r_p[8]) + r_td;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p  <= n_p;
            r_tx <= SUM_W'($signed(i_row_x_b[63:32]));
            r_ty <= SUM_W'($signed(i_row_y_b[63:32]));
            r_td <= SUM_W'($signed(i_row_d_b[63:32]));
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_sd <= n_sd;
        end
    end

    assign o_entry = {(r_sd == '0), r_sd, r_sy, r_sx};

endmodule

// ===== design/ppp_queue.sv =====
// ----------------------------------------------------------------------------
// ppp_queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module ppp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = ppp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== design/ppp_back.sv =====
// ----------------------------------------------------------------------------
// ppp_back
// Pipelined restoring divider, centre offset, truncation and saturation.
// ----------------------------------------------------------------------------
module ppp_back #(
    parameter int PIXEL_BITS = ppp_pkg::PIXEL_BITS_DEF,
    parameter int SUM_W      = 50
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_qvalid,
    input  logic [3*SUM_W:0]             i_entry,
    output logic                         o_pop,
    input  logic [ppp_pkg::SIZE_W-1:0]   i_img_size,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ppp_pkg::PIX_W-1:0]    o_row,
    output logic [ppp_pkg::PIX_W-1:0]    o_col,
    output logic                         o_dz
);

    localparam int QB = (PIXEL_BITS > 16) ? PIXEL_BITS + 2 : 18;
    localparam int WW = SUM_W + QB;
    localparam int VW = QB + 2;
    localparam logic signed [VW-1:0] PMAX = VW'((64'sd1 <<< (PIXEL_BITS-1)) - 1);
    localparam logic signed [VW-1:0] PMIN = VW'(-(64'sd1 <<< (PIXEL_BITS-1)));

    logic                   en;
    logic                   r_v   [QB+1];
    logic [SUM_W-1:0]       r_ac  [QB+1];
    logic [SUM_W-1:0]       r_ar  [QB+1];
    logic [SUM_W-1:0]       r_b   [QB+1];
    logic [QB-1:0]          r_qc  [QB+1];
    logic [QB-1:0]          r_qr  [QB+1];
    ppp_pkg::t_flags        r_f   [QB+1];

    logic signed [SUM_W-1:0] ex, ey, ed;
    logic [SUM_W-1:0]        mx, my, md;
    ppp_pkg::t_flags         n_f;

    logic                        r_ov, r_dz;
    logic [ppp_pkg::PIX_W-1:0]   r_row, r_col;
    logic [16:0]                 base_c, base_r;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && i_qvalid;

    function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    always_comb begin
        ex = i_entry[SUM_W-1:0];
        ey = i_entry[2*SUM_W-1:SUM_W];
        ed = i_entry[3*SUM_W-1:2*SUM_W];
        mx = mag(ex);
        my = mag(ey);
        md = mag(ed);
        n_f.dz    = i_entry[3*SUM_W];
        n_f.neg_c = ex[SUM_W-1] ^ ed[SUM_W-1];
        n_f.neg_r = ~(ey[SUM_W-1] ^ ed[SUM_W-1]);
        n_f.ovf_c = WW'(mx) >= (WW'(md) << QB);
        n_f.ovf_r = WW'(my) >= (WW'(md) << QB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_qvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ac[0] <= mx;
            r_ar[0] <= my;
            r_b[0]  <= md;
            r_qc[0] <= '0;
            r_qr[0] <= '0;
            r_f[0]  <= n_f;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QB; k++) begin : g_div
        logic [WW-1:0] sh;
        logic          gc, gr;
        assign sh = WW'(r_b[k-1]) << (QB - k);
        assign gc = WW'(r_ac[k-1]) >= sh;
        assign gr = WW'(r_ar[k-1]) >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ac[k] <= gc ? r_ac[k-1] - sh[SUM_W-1:0] : r_ac[k-1];
                r_ar[k] <= gr ? r_ar[k-1] - sh[SUM_W-1:0] : r_ar[k-1];
                r_qc[k] <= {r_qc[k-1][QB-2:0], gc};
                r_qr[k] <= {r_qr[k-1][QB-2:0], gr};
                r_b[k]  <= r_b[k-1];
                r_f[k]  <= r_f[k-1];
            end
        end
    end

    function automatic logic [ppp_pkg::PIX_W-1:0] fin(input logic [16:0] base,
                                                      input logic [QB-1:0] q,
                                                      input logic ovf,
                                                      input logic neg,
                                                      input logic rnz);
        logic [QB-1:0]        qs;
        logic signed [VW-1:0] v;
        qs = ovf ? '1 : q;
        v  = neg ? $signed(VW'(base)) - $signed(VW'(qs))
                 : $signed(VW'(base)) + $signed(VW'(qs));
        // pull toward zero when a fraction remains
        if (rnz && !neg && v < 0)
            v = v + VW'(1);
        else if (rnz && neg && v > 0)
            v = v - VW'(1);
        if (v > PMAX) v = PMAX;
        if (v < PMIN) v = PMIN;
        return v[ppp_pkg::PIX_W-1:0];
    endfunction

    assign base_c = 17'(i_img_size[15:1]);
    assign base_r = 17'(i_img_size[31:16]) - 17'(i_img_size[31:17]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dz <= r_f[QB].dz;
            if (r_f[QB].dz) begin
                r_row <= '0;
                r_col <= '0;
            end else begin
                r_col <= fin(base_c, r_qc[QB], r_f[QB].ovf_c, r_f[QB].neg_c,
                             r_ac[QB] != '0);
                r_row <= fin(base_r, r_qr[QB], r_f[QB].ovf_r, r_f[QB].neg_r,
                             r_ar[QB] != '0);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_dz    = r_dz;

endmodule

// ===== design/perspective_point_projection_unit.sv =====
// ----------------------------------------------------------------------------
// perspective_point_projection_unit
// Projects world points through a 3x4 camera matrix onto pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one point a word: tdata = {z, y, x}, each signed
//   Q16.16. Master stream gives one pixel a word: tdata = {col, row},
//   tuser = zero-depth flag (row and col then read zero).
//   Configuration: pulse i_cfg_we with i_cfg_idx / i_cfg_wdata while no
//   point is in flight; the matrix rows and image size take effect at once.
// Throughput: one point per cycle, sustained, while the master stream is ready.
// Pipeline: a register of matrix products, a register of sums, the queue,
//   a register that takes magnitudes, one divider stage per quotient bit
//   (18 at the default pixel width) and the output register.
// Reset: clears all valid flags and loads the identity matrix and a
//   640 x 480 image.
// Stalls: a stalled master holds the divider; the front keeps taking
//   points until the four-word queue fills, then drops s_axis_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module perspective_point_projection_unit #(
    parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF,
    parameter int PIXEL_BITS = ppp_pkg::PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [95:0]                  s_axis_tdata,   // point_x, point_y, point_z
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,   // pixel_row, pixel_col
    output logic                         m_axis_tuser,   // depth_zero
    input  logic                         i_cfg_we,
    input  logic [ppp_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [ppp_pkg::REG_W-1:0]    i_cfg_wdata
);

    localparam int SUM_W = 66 - FRAC_BITS;
    localparam int ENT_W = 3 * SUM_W + 1;

    logic [ppp_pkg::REG_W-1:0]  r_rxa, r_rxb, r_rya, r_ryb, r_rda, r_rdb;
    logic [ppp_pkg::SIZE_W-1:0] r_img;

    logic              push, full, pop, qvalid;
    logic [ENT_W-1:0]  f_entry, q_entry;
    logic [15:0]       row, col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rxa <= ppp_pkg::RST_ROW_X_A;
            r_rxb <= ppp_pkg::RST_ROW_X_B;
            r_rya <= ppp_pkg::RST_ROW_Y_A;
            r_ryb <= ppp_pkg::RST_ROW_Y_B;
            r_rda <= ppp_pkg::RST_ROW_D_A;
            r_rdb <= ppp_pkg::RST_ROW_D_B;
            r_img <= ppp_pkg::RST_IMG_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppp_pkg::REG_ROW_X_A:  r_rxa <= i_cfg_wdata;
                ppp_pkg::REG_ROW_X_B:  r_rxb <= i_cfg_wdata;
                ppp_pkg::REG_ROW_Y_A:  r_rya <= i_cfg_wdata;
                ppp_pkg::REG_ROW_Y_B:  r_ryb <= i_cfg_wdata;
                ppp_pkg::REG_ROW_D_A:  r_rda <= i_cfg_wdata;
                ppp_pkg::REG_ROW_D_B:  r_rdb <= i_cfg_wdata;
                ppp_pkg::REG_IMG_SIZE: r_img <= i_cfg_wdata[ppp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    ppp_front #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_x       (s_axis_tdata[31:0]),
        .i_y       (s_axis_tdata[63:32]),
        .i_z       (s_axis_tdata[95:64]),
        .i_row_x_a (r_rxa),
        .i_row_x_b (r_rxb),
        .i_row_y_a (r_rya),
        .i_row_y_b (r_ryb),
        .i_row_d_a (r_rda),
        .i_row_d_b (r_rdb),
        .o_push    (push),
        .i_full    (full),
        .o_entry   (f_entry)
    );

    ppp_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (q_entry)
    );

    ppp_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .SUM_W      (SUM_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qvalid   (qvalid),
        .i_entry    (q_entry),
        .o_pop      (pop),
        .i_img_size (r_img),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_row      (row),
        .o_col      (col),
        .o_dz       (m_axis_tuser)
    );

    assign m_axis_tdata = {col, row};

    `ASSERT_IMPLY(a_dz_zero_pixel, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)
    `ASSERT_NEXT(a_rst_no_out, i_clk, !i_rst_n, !m_axis_tvalid)
    `ASSERT_IMPLY(a_rst_ready, i_clk, i_rst_n, $past(!i_rst_n), s_axis_tready)

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perspective point projection unit: points are
// streamed in with random gaps, pixels are drained with random stalls and
// every pixel word is checked against a bit-exact fixed-point projection.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic        dz;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // point_x, point_y, point_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // pixel_row, pixel_col
    logic        m_axis_tuser;        // depth_zero
    logic                         i_cfg_we = 1'b0;
    logic [ppp_pkg::IDX_W-1:0]    i_cfg_idx = '0;
    logic [ppp_pkg::REG_W-1:0]    i_cfg_wdata = '0;

    perspective_point_projection_unit dut (.*);

    always #5 i_clk = ~i_clk;

    logic [63:0] cam [0:6];
    logic [95:0] point_q [$];
    t_pixel      pixel_q [$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  s_gap_max = 0, r_gap_max = 0;
    int  s_wait = 0, r_wait = 0;
    int  hold_cycles = 0;
    bit  s_took = 0, r_took = 0;

    function automatic longint floor_prod(logic [31:0] c, longint v);
        longint p;
        p = longint'(signed'(c)) * v;
        return p >>> 16;
    endfunction

    function automatic longint row_sum(logic [63:0] a, logic [63:0] b,
                                       longint x, longint y, longint z);
        return floor_prod(a[31:0], x) + floor_prod(a[63:32], y)
             + floor_prod(b[31:0], z) + longint'(signed'(b[63:32]));
    endfunction

    // trunc(base + sgn * n / d) on the exact quotient
    function automatic longint trunc_off(longint base, longint n, longint d, int sgn);
        longint q, r, s;
        int fs;
        q = n / d;
        r = n % d;
        fs = 0;
        if (r != 0) fs = ((r < 0) != (d < 0)) ? -1 : 1;
        if (sgn < 0) begin
            q = -q;
            fs = -fs;
        end
        s = base + q;
        if (fs > 0 && s < 0) s = s + 1;
        else if (fs < 0 && s > 0) s = s - 1;
        return s;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_pixel project(logic [95:0] w);
        longint x, y, z, cx, cy, cd, wd, ht;
        t_pixel p;
        x = longint'(signed'(w[31:0]));
        y = longint'(signed'(w[63:32]));
        z = longint'(signed'(w[95:64]));
        cx = row_sum(cam[0], cam[1], x, y, z);
        cy = row_sum(cam[2], cam[3], x, y, z);
        cd = row_sum(cam[4], cam[5], x, y, z);
        wd = longint'(cam[6][15:0]);
        ht = longint'(cam[6][31:16]);
        p = '0;
        if (cd == 0) begin
            p.dz = 1'b1;
        end else begin
            p.row = clamp16(trunc_off(ht - ht / 2, cy, cd, -1));
            p.col = clamp16(trunc_off(wd / 2, cx, cd, 1));
        end
        return p;
    endfunction

    // monitor: predict on accepted points, check accepted pixels
    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_q.push_back(project(s_axis_tdata));
                s_took = 1;
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                r_took = 1;
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
                if (pixel_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word row=%0d col=%0d dz=%0b", $time,
                             $signed(got.row), $signed(got.col), got.dz);
                end else begin
                    want = pixel_q.pop_front();
                    if (got.row !== want.row) begin
                        errors++;
                        $display("%0t: pixel_row expected %0d actual %0d", $time,
                                 $signed(want.row), $signed(got.row));
                    end
                    if (got.col !== want.col) begin
                        errors++;
                        $display("%0t: pixel_col expected %0d actual %0d", $time,
                                 $signed(want.col), $signed(got.col));
                    end
                    if (got.dz !== want.dz) begin
                        errors++;
                        $display("%0t: depth_zero expected %0b actual %0b", $time,
                                 want.dz, got.dz);
                    end
                end
            end
            if (idle_cycles >= 5000) begin
                $display("perspective_point_projection_unit regression: fail");
                $finish;
            end
        end
    end

    // point driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_took)) begin
            s_took = 0;
            if (s_wait > 0) begin
                s_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (point_q.size() > 0) begin
                s_axis_tdata  <= point_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_wait = $urandom_range(0, s_gap_max);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // pixel receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (!m_axis_tready || r_took) begin
                r_took = 0;
                if (r_wait > 0) begin
                    r_wait--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    r_wait = $urandom_range(0, r_gap_max);
                end
            end
        end
    end

    task automatic wr(logic [ppp_pkg::IDX_W-1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        cam[idx] = (idx == ppp_pkg::REG_IMG_SIZE) ? {32'd0, val[31:0]} : val;
    endtask

    task automatic load_cam(logic [63:0] xa, logic [63:0] xb, logic [63:0] ya,
                            logic [63:0] yb, logic [63:0] da, logic [63:0] db,
                            logic [63:0] sz);
        wr(ppp_pkg::REG_ROW_X_A, xa);
        wr(ppp_pkg::REG_ROW_X_B, xb);
        wr(ppp_pkg::REG_ROW_Y_A, ya);
        wr(ppp_pkg::REG_ROW_Y_B, yb);
        wr(ppp_pkg::REG_ROW_D_A, da);
        wr(ppp_pkg::REG_ROW_D_B, db);
        wr(ppp_pkg::REG_IMG_SIZE, sz);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (point_q.size() > 0 || pixel_q.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    // coefficient pair of modest Q16.16 values
    function automatic logic [63:0] coef_pair(int span);
        int a, b;
        a = $urandom_range(0, 2 * span) - span;
        b = $urandom_range(0, 2 * span) - span;
        return {b, a};
    endfunction

    function automatic logic [31:0] coord(int mode);
        int v;
        case (mode)
            0: v = $urandom;
            1: v = ($urandom_range(0, 400) - 200) <<< 16 | $urandom_range(0, 65535);
            default: v = $urandom_range(0, 1 << 20) - (1 << 19);
        endcase
        return v;
    endfunction

    task automatic random_points(int n, int mode_max);
        for (int i = 0; i < n; i++)
            point_q.push_back({coord($urandom_range(0, mode_max)),
                               coord($urandom_range(0, mode_max)),
                               coord($urandom_range(0, mode_max))});
    endtask

    initial begin
        cam[0] = ppp_pkg::RST_ROW_X_A;
        cam[1] = ppp_pkg::RST_ROW_X_B;
        cam[2] = ppp_pkg::RST_ROW_Y_A;
        cam[3] = ppp_pkg::RST_ROW_Y_B;
        cam[4] = ppp_pkg::RST_ROW_D_A;
        cam[5] = ppp_pkg::RST_ROW_D_B;
        cam[6] = {32'd0, ppp_pkg::RST_IMG_SIZE};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset matrix, zero depth, extremes, negative depth, saturation
        point_q.push_back({32'd0, 32'd0, 32'd0});
        point_q.push_back({32'h0001_0000, 32'd0, 32'd0});
        point_q.push_back({32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000});
        point_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        point_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        point_q.push_back({32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000});
        point_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        point_q.push_back({32'h0000_8000, 32'h0003_0000, 32'hFFFD_0000});
        point_q.push_back({32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF});
        point_q.push_back({32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
        drain();

        // zero and all-ones matrices, empty and full image
        load_cam('0, '0, '0, '0, '0, '0, '0);
        point_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678});
        point_q.push_back({32'h0, 32'h0, 32'h0});
        drain();
        load_cam('1, '1, '1, '1, '1, '1, '1);
        point_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678});
        point_q.push_back({32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000});
        point_q.push_back({32'h0, 32'h0, 32'h0});
        point_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        drain();

        // random phases; phase 0 without gaps, phase 2 with a long receiver hold
        for (int ph = 0; ph < 9; ph++) begin
            s_gap_max = (ph == 0) ? 0 : $urandom_range(0, 10);
            r_gap_max = (ph == 0) ? 0 : $urandom_range(0, 10);
            case (ph % 3)
                0: load_cam(r64(), r64(), r64(), r64(), r64(), r64(), r64());
                1: load_cam(coef_pair(1 << 26), {$urandom, 32'(coef_pair(1 << 18))},
                            coef_pair(1 << 26), {$urandom, 32'(coef_pair(1 << 18))},
                            coef_pair(1 << 14), {32'($urandom_range(0, 1 << 22)),
                                                 32'($urandom_range(1 << 15, 1 << 17))},
                            {32'd0, $urandom});
                default: load_cam({32'd0, 32'($urandom_range(1 << 16, 1 << 26))},
                                  {$urandom_range(0, 1 << 24), 32'd0},
                                  {32'($urandom_range(1 << 16, 1 << 26)), 32'd0},
                                  {$urandom_range(0, 1 << 24), 32'd0},
                                  64'd0, {32'($urandom_range(0, 1 << 20)), 32'h0001_0000},
                                  {32'd0, 16'($urandom_range(1, 2048)),
                                   16'($urandom_range(1, 2048))});
            endcase
            if (ph == 2) hold_cycles = 300;
            random_points(60, (ph % 3 == 0) ? 0 : 2);
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (errors == 0 && pixel_q.size() == 0)
            $display("perspective_point_projection_unit regression: pass");
        else
            $display("perspective_point_projection_unit regression: fail");
        $finish;
    end

endmodule
